// ===== sv/mkmc_pkg.sv =====
package mkmc_pkg;

    localparam int NODES    = 4096;
    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = NODE_W + 1;
    localparam int ALPHABET = 26;
    localparam int LET_W    = 5;
    localparam int COL_W    = $clog2(ALPHABET);
    localparam int GOTO_DEPTH = NODES * ALPHABET;
    localparam int GOTO_AW  = $clog2(GOTO_DEPTH);
    localparam int SUM_W    = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_KEY   = 2'd1,
        CMD_BUILD = 2'd2,
        CMD_TEXT  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_ZROW,
        OP_DROP,
        OP_RDSLOT,
        OP_ADDCHK,
        OP_ENDCHK,
        OP_ENDWR,
        OP_BSTART,
        OP_ROOTRD,
        OP_ROOTCHK,
        OP_POP,
        OP_BX,
        OP_BF,
        OP_ERV,
        OP_ERF,
        OP_EW,
        OP_SCRD,
        OP_SCJ,
        OP_WALK,
        OP_WALK2,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic letter_ok;
        logic built;
        logic dropped;
        logic last;
        logic slot_hit;
        logic room;
        logic c_last;
        logic q_empty;
        logic j_zero;
        logic out_free;
    } dp_stat_t;

    function automatic logic [GOTO_AW-1:0] goto_addr(logic [NODE_W-1:0] node,
                                                     logic [COL_W-1:0] col);
        goto_addr = GOTO_AW'(node) * GOTO_AW'(ALPHABET) + GOTO_AW'(col);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

// ===== sv/mkmc_ram.sv =====
module mkmc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/mkmc_ctrl.sv =====
module mkmc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mkmc_pkg::dp_stat_t stat,
    output mkmc_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_RST_ZROW, S_IDLE, S_DISPATCH, S_CLR, S_CLR_ZROW, S_DROP, S_RDSLOT,
        S_ADDCHK, S_NEW_ZROW, S_ENDCHK, S_ENDWR, S_BSTART, S_ROOTRD, S_ROOTCHK,
        S_POP, S_BX, S_BF, S_ERV, S_ERF, S_EW, S_SCRD, S_SCJ, S_WALK, S_WALK2,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RST_ZROW: if (stat.c_last) state_next = S_IDLE;
            S_IDLE:     if (in_valid) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (stat.cmd)
                    mkmc_pkg::CMD_CLEAR: state_next = S_CLR;
                    mkmc_pkg::CMD_KEY:
                    begin
                        if (!stat.letter_ok || stat.built) state_next = S_FIN;
                        else if (stat.dropped)            state_next = S_DROP;
                        else                              state_next = S_RDSLOT;
                    end
                    mkmc_pkg::CMD_BUILD:
                        state_next = stat.built ? S_FIN : S_BSTART;
                    default:
                        state_next = (!stat.letter_ok || !stat.built) ? S_FIN : S_SCRD;
                endcase
            end
            S_CLR:      state_next = S_CLR_ZROW;
            S_CLR_ZROW: if (stat.c_last) state_next = S_FIN;
            S_DROP:     state_next = S_FIN;
            S_RDSLOT:   state_next = S_ADDCHK;
            S_ADDCHK:
            begin
                if (!stat.slot_hit && stat.room) state_next = S_NEW_ZROW;
                else                             state_next = S_ENDCHK;
            end
            S_NEW_ZROW: if (stat.c_last) state_next = S_ENDCHK;
            S_ENDCHK:   state_next = (stat.last && !stat.dropped) ? S_ENDWR : S_FIN;
            S_ENDWR:    state_next = S_FIN;
            S_BSTART:   state_next = S_ROOTRD;
            S_ROOTRD:   state_next = S_ROOTCHK;
            S_ROOTCHK:  state_next = stat.c_last ? S_POP : S_ROOTRD;
            S_POP:      state_next = stat.q_empty ? S_FIN : S_BX;
            S_BX:       state_next = S_BF;
            S_BF:       state_next = S_ERV;
            S_ERV:      state_next = S_ERF;
            S_ERF:      state_next = S_EW;
            S_EW:       state_next = stat.c_last ? S_POP : S_ERV;
            S_SCRD:     state_next = S_SCJ;
            S_SCJ:      state_next = S_WALK;
            S_WALK:     state_next = stat.j_zero ? S_FIN : S_WALK2;
            S_WALK2:    state_next = S_WALK;
            S_FIN:      if (stat.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = mkmc_pkg::OP_NONE;
        case (state_reg)
            S_RST_ZROW, S_CLR_ZROW, S_NEW_ZROW: cmd.op = mkmc_pkg::OP_ZROW;
            S_IDLE:    cmd.op = in_valid ? mkmc_pkg::OP_LATCH : mkmc_pkg::OP_NONE;
            S_CLR:     cmd.op = mkmc_pkg::OP_CLEAR;
            S_DROP:    cmd.op = mkmc_pkg::OP_DROP;
            S_RDSLOT:  cmd.op = mkmc_pkg::OP_RDSLOT;
            S_ADDCHK:  cmd.op = mkmc_pkg::OP_ADDCHK;
            S_ENDCHK:  cmd.op = mkmc_pkg::OP_ENDCHK;
            S_ENDWR:   cmd.op = mkmc_pkg::OP_ENDWR;
            S_BSTART:  cmd.op = mkmc_pkg::OP_BSTART;
            S_ROOTRD:  cmd.op = mkmc_pkg::OP_ROOTRD;
            S_ROOTCHK: cmd.op = mkmc_pkg::OP_ROOTCHK;
            S_POP:     cmd.op = mkmc_pkg::OP_POP;
            S_BX:      cmd.op = mkmc_pkg::OP_BX;
            S_BF:      cmd.op = mkmc_pkg::OP_BF;
            S_ERV:     cmd.op = mkmc_pkg::OP_ERV;
            S_ERF:     cmd.op = mkmc_pkg::OP_ERF;
            S_EW:      cmd.op = mkmc_pkg::OP_EW;
            S_SCRD:    cmd.op = mkmc_pkg::OP_SCRD;
            S_SCJ:     cmd.op = mkmc_pkg::OP_SCJ;
            S_WALK:    cmd.op = mkmc_pkg::OP_WALK;
            S_WALK2:   cmd.op = mkmc_pkg::OP_WALK2;
            S_FIN:     cmd.op = mkmc_pkg::OP_FIN;
            default:   cmd.op = mkmc_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RST_ZROW;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DISPATCH)
        else $error("accepted item not dispatched");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN && !stat.out_free |=> state_reg == S_FIN)
        else $error("result dropped while output busy");

endmodule

// ===== sv/mkmc_dp.sv =====
module mkmc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mkmc_pkg::dp_cmd_t             cmd,
    output mkmc_pkg::dp_stat_t            stat,
    input  logic [1:0]                    cmd_in,
    input  logic [mkmc_pkg::LET_W-1:0]    letter,
    input  logic                          word_end,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [mkmc_pkg::SUM_W-1:0]    match_total,
    output logic [mkmc_pkg::SUM_W-1:0]    found_here,
    output logic                          store_full
);

    localparam int NW = mkmc_pkg::NODE_W;
    localparam int CW = mkmc_pkg::CNT_W;
    localparam int KW = mkmc_pkg::COL_W;
    localparam int SW = mkmc_pkg::SUM_W;

    mkmc_pkg::cmd_t cmd_reg, cmd_next;
    logic [mkmc_pkg::LET_W-1:0] letter_reg, letter_next;
    logic last_reg, last_next;
    logic [NW-1:0] insert_reg, insert_next, scan_reg, scan_next, zr_reg, zr_next;
    logic [NW-1:0] x_reg, x_next, f_reg, f_next, v_reg, v_next, j_reg, j_next;
    logic [CW-1:0] nodes_reg, nodes_next, head_reg, head_next, tail_reg, tail_next;
    logic [KW-1:0] col_reg, col_next, col_step;
    logic [SW-1:0] found_reg, found_next, total_reg, total_next;
    logic built_reg, built_next, dropped_reg, dropped_next, full_reg, full_next;
    logic out_valid_reg, out_valid_next, out_full_reg, out_full_next;
    logic [SW-1:0] out_total_reg, out_total_next, out_found_reg, out_found_next;
    logic c_last, out_free;

    logic                          g_we;
    logic [mkmc_pkg::GOTO_AW-1:0]  g_waddr, g_raddr;
    logic [NW-1:0]                 g_wdata, g_rdata;
    logic                          f_we;
    logic [NW-1:0]                 f_waddr, f_raddr, f_wdata, f_rdata;
    logic                          e_we;
    logic [NW-1:0]                 e_waddr, e_raddr;
    logic [SW-1:0]                 e_wdata, e_rdata;
    logic                          q_we;
    logic [NW-1:0]                 q_waddr, q_raddr, q_wdata, q_rdata;

    mkmc_ram #(.WIDTH(NW), .DEPTH(mkmc_pkg::GOTO_DEPTH)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata));
    mkmc_ram #(.WIDTH(NW), .DEPTH(mkmc_pkg::NODES)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata));
    mkmc_ram #(.WIDTH(SW), .DEPTH(mkmc_pkg::NODES)) u_end (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    mkmc_ram #(.WIDTH(NW), .DEPTH(mkmc_pkg::NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));

    assign c_last   = (col_reg == KW'(mkmc_pkg::ALPHABET - 1));
    assign col_step = c_last ? '0 : col_reg + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    assign stat.cmd       = cmd_reg;
    assign stat.letter_ok = (letter_reg < mkmc_pkg::LET_W'(mkmc_pkg::ALPHABET));
    assign stat.built     = built_reg;
    assign stat.dropped   = dropped_reg;
    assign stat.last      = last_reg;
    assign stat.slot_hit  = (g_rdata != '0);
    assign stat.room      = (nodes_reg < CW'(mkmc_pkg::NODES));
    assign stat.c_last    = c_last;
    assign stat.q_empty   = (head_reg == tail_reg);
    assign stat.j_zero    = (j_reg == '0);
    assign stat.out_free  = out_free;

    assign out_valid   = out_valid_reg;
    assign match_total = out_total_reg;
    assign found_here  = out_found_reg;
    assign store_full  = out_full_reg;

    always_comb
    begin
        cmd_next = cmd_reg;         letter_next = letter_reg;   last_next = last_reg;
        insert_next = insert_reg;   scan_next = scan_reg;       zr_next = zr_reg;
        x_next = x_reg;             f_next = f_reg;             v_next = v_reg;
        j_next = j_reg;             nodes_next = nodes_reg;     head_next = head_reg;
        tail_next = tail_reg;       col_next = col_reg;         found_next = found_reg;
        total_next = total_reg;     built_next = built_reg;     dropped_next = dropped_reg;
        full_next = full_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_total_next = out_total_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;

        g_we = 1'b0; g_waddr = mkmc_pkg::goto_addr(x_reg, col_reg); g_wdata = '0;
        g_raddr = mkmc_pkg::goto_addr(insert_reg, KW'(letter_reg));
        f_we = 1'b0; f_waddr = v_reg; f_wdata = '0; f_raddr = j_reg;
        e_we = 1'b0; e_waddr = j_reg; e_wdata = '0; e_raddr = j_reg;
        q_we = 1'b0; q_waddr = tail_reg[NW-1:0]; q_wdata = v_reg; q_raddr = head_reg[NW-1:0];

        case (cmd.op)
            mkmc_pkg::OP_LATCH:
            begin
                cmd_next    = mkmc_pkg::cmd_t'(cmd_in);
                letter_next = letter;
                last_next   = word_end;
                found_next  = '0;
                full_next   = 1'b0;
            end
            mkmc_pkg::OP_CLEAR:
            begin
                nodes_next   = CW'(1);
                insert_next  = '0;
                scan_next    = '0;
                total_next   = '0;
                built_next   = 1'b0;
                dropped_next = 1'b0;
                zr_next      = '0;
                col_next     = '0;
            end
            mkmc_pkg::OP_ZROW:
            begin
                g_we     = 1'b1;
                g_waddr  = mkmc_pkg::goto_addr(zr_reg, col_reg);
                col_next = col_step;
            end
            mkmc_pkg::OP_DROP:
            begin
                full_next = 1'b1;
                if (last_reg)
                begin
                    insert_next  = '0;
                    dropped_next = 1'b0;
                end
            end
            mkmc_pkg::OP_RDSLOT:
            begin
                g_raddr = mkmc_pkg::goto_addr(insert_reg, KW'(letter_reg));
            end
            mkmc_pkg::OP_ADDCHK:
            begin
                if (g_rdata != '0)
                begin
                    insert_next = g_rdata;
                end
                else if (stat.room)
                begin
                    // new node: link it, zero its count; its row is swept next
                    g_we        = 1'b1;
                    g_waddr     = mkmc_pkg::goto_addr(insert_reg, KW'(letter_reg));
                    g_wdata     = nodes_reg[NW-1:0];
                    e_we        = 1'b1;
                    e_waddr     = nodes_reg[NW-1:0];
                    insert_next = nodes_reg[NW-1:0];
                    zr_next     = nodes_reg[NW-1:0];
                    col_next    = '0;
                    nodes_next  = nodes_reg + 1'b1;
                end
                else
                begin
                    full_next    = 1'b1;
                    dropped_next = 1'b1;
                end
            end
            mkmc_pkg::OP_ENDCHK:
            begin
                e_raddr = insert_reg;
                if (last_reg && dropped_reg)
                begin
                    insert_next  = '0;
                    dropped_next = 1'b0;
                end
            end
            mkmc_pkg::OP_ENDWR:
            begin
                e_we         = 1'b1;
                e_waddr      = insert_reg;
                e_wdata      = mkmc_pkg::sat_add(e_rdata, SW'(1));
                insert_next  = '0;
                dropped_next = 1'b0;
            end
            mkmc_pkg::OP_BSTART:
            begin
                col_next  = '0;
                head_next = '0;
                tail_next = '0;
            end
            mkmc_pkg::OP_ROOTRD:
            begin
                g_raddr = mkmc_pkg::goto_addr('0, col_reg);
            end
            mkmc_pkg::OP_ROOTCHK:
            begin
                if (g_rdata != '0)
                begin
                    f_we      = 1'b1;
                    f_waddr   = g_rdata;
                    q_we      = 1'b1;
                    q_wdata   = g_rdata;
                    tail_next = tail_reg + 1'b1;
                end
                col_next = col_step;
            end
            mkmc_pkg::OP_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    built_next = 1'b1;
                end
                else
                begin
                    head_next = head_reg + 1'b1;
                end
            end
            mkmc_pkg::OP_BX:
            begin
                x_next  = q_rdata;
                f_raddr = q_rdata;
            end
            mkmc_pkg::OP_BF:
            begin
                f_next   = f_rdata;
                col_next = '0;
            end
            mkmc_pkg::OP_ERV:
            begin
                g_raddr = mkmc_pkg::goto_addr(x_reg, col_reg);
            end
            mkmc_pkg::OP_ERF:
            begin
                v_next  = g_rdata;
                g_raddr = mkmc_pkg::goto_addr(f_reg, col_reg);
            end
            mkmc_pkg::OP_EW:
            begin
                if (v_reg != '0)
                begin
                    f_we      = 1'b1;
                    f_wdata   = g_rdata;
                    q_we      = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                else
                begin
                    // missing edge borrows the failure node's edge
                    g_we    = 1'b1;
                    g_wdata = g_rdata;
                end
                col_next = col_step;
            end
            mkmc_pkg::OP_SCRD:
            begin
                g_raddr = mkmc_pkg::goto_addr(scan_reg, KW'(letter_reg));
            end
            mkmc_pkg::OP_SCJ:
            begin
                j_next    = g_rdata;
                scan_next = g_rdata;
            end
            mkmc_pkg::OP_WALK:
            begin
                if (j_reg == '0)
                begin
                    total_next = mkmc_pkg::sat_add(total_reg, found_reg);
                end
            end
            mkmc_pkg::OP_WALK2:
            begin
                found_next = mkmc_pkg::sat_add(found_reg, e_rdata);
                e_we       = 1'b1;
                j_next     = f_rdata;
            end
            mkmc_pkg::OP_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = total_reg;
                    out_found_next = found_reg;
                    out_full_next  = full_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg     <= CW'(1);
            insert_reg    <= '0;
            scan_reg      <= '0;
            zr_reg        <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            col_reg       <= '0;
            total_reg     <= '0;
            built_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cmd_reg       <= mkmc_pkg::CMD_CLEAR;
        end
        else
        begin
            nodes_reg     <= nodes_next;
            insert_reg    <= insert_next;
            scan_reg      <= scan_next;
            zr_reg        <= zr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            col_reg       <= col_next;
            total_reg     <= total_next;
            built_reg     <= built_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg    <= letter_next;
        last_reg      <= last_next;
        x_reg         <= x_next;
        f_reg         <= f_next;
        v_reg         <= v_next;
        j_reg         <= j_next;
        found_reg     <= found_next;
        full_reg      <= full_next;
        out_total_reg <= out_total_next;
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
    end

    a_nodes_range: assert property (@(posedge clk) disable iff (!rst_n)
        nodes_reg != '0 && nodes_reg <= CW'(mkmc_pkg::NODES))
        else $error("node count out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("queue head passed tail");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == mkmc_pkg::OP_FIN))
        else $error("result appeared outside finish step");

endmodule

// ===== sv/multi_keyword_match_counter.sv =====
// Multi-keyword match counter (Aho-Corasick automaton), letters a..z as 0..25.
// Input channel (cmd, letter, word_end; in_valid / in_stall): one item is a
// clear, one keyword letter (word_end closes the keyword), a build of goto and
// failure links, or one text letter. Output channel (match_total, found_here,
// store_full; out_valid / out_stall): exactly one result per input item.
// Items are worked one at a time by a state machine over four RAMs with one
// write port and one registered read port (goto table, failure links, keyword
// counts, build queue). Steps per item: a clear sweeps the root row; a keyword
// letter reads and checks its goto slot, sweeps the row of a new node, and
// bumps the keyword count when it closes a keyword, while a letter of a
// dropped keyword goes straight to its result; a text letter takes its goto
// step, then walks the failure chain summing keyword counts and clearing
// each count it reads; a build checks every root column, then works the
// queue, every edge of each trie node; an ignored item goes straight to its
// result. in_stall falls as the result is registered. The next item is taken
// while a result waits; the finish step holds only while the previous result
// is still stalled. After reset the root row of the goto table is swept with
// in_stall high; out_valid is low through reset.
module multi_keyword_match_counter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 cmd,
    input  logic [mkmc_pkg::LET_W-1:0] letter,
    input  logic                       word_end,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [mkmc_pkg::SUM_W-1:0] match_total,
    output logic [mkmc_pkg::SUM_W-1:0] found_here,
    output logic                       store_full
);

    mkmc_pkg::dp_cmd_t  dp_cmd;
    mkmc_pkg::dp_stat_t dp_stat;

    // sequencer: one state per memory access step
    mkmc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // trie storage, pointers, totals and the output register
    mkmc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .cmd_in      (cmd),
        .letter      (letter),
        .word_end    (word_end),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .match_total (match_total),
        .found_here  (found_here),
        .store_full  (store_full)
    );

endmodule
